// ===== rtl/nss_pkg.sv =====
// shared constants and types for the nearest segment search block
`timescale 1ns / 1ps
package nss_pkg;

  localparam int MAX_SEGMENTS = 65536;
  localparam int CNT_W = $clog2(MAX_SEGMENTS);

  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int DIG_W = 17;
  localparam int NDIG = 4;
  localparam int OP_W = DIG_W * NDIG;
  localparam int WIDE_W = 2 * OP_W;
  localparam int FRAC_W = 32;
  localparam int Q_W = FRAC_W + 1;
  localparam int DIST_W = 32;
  localparam int IDX_W = 16;
  localparam int DSQ_W = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_QSX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QSY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QSZ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QEX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QEY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_QEZ = 3'd5;

  typedef logic signed [OP_W-1:0] op_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

endpackage

// ===== rtl/nss_if.sv =====
// handshake channels for candidate items and result items
`timescale 1ns / 1ps
interface nss_cand_if import nss_pkg::*; ;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] cand_start_x;
  logic signed [COORD_W-1:0] cand_start_y;
  logic signed [COORD_W-1:0] cand_start_z;
  logic signed [COORD_W-1:0] cand_end_x;
  logic signed [COORD_W-1:0] cand_end_y;
  logic signed [COORD_W-1:0] cand_end_z;
  logic is_connected;
  logic last_candidate;

  modport source(output valid, cand_start_x, cand_start_y, cand_start_z, cand_end_x,
                 cand_end_y, cand_end_z, is_connected, last_candidate, input ready);
  modport sink(input valid, cand_start_x, cand_start_y, cand_start_z, cand_end_x,
               cand_end_y, cand_end_z, is_connected, last_candidate, output ready);
endinterface

interface nss_res_if import nss_pkg::*; ;
  logic valid;
  logic ready;
  logic [DIST_W-1:0] nearest_dist;
  logic [IDX_W-1:0] best_index;
  logic found;

  modport source(output valid, nearest_dist, best_index, found, input ready);
  modport sink(input valid, nearest_dist, best_index, found, output ready);
endinterface

// ===== rtl/nearest_segment_search.sv =====
// top level: nearest segment search over a stream of candidate segments
// a connected candidate skips the distance work and goes straight to the finish state
// an unconnected candidate keeps it busy for 30 products on the single shared
// 17-bit digit-serial multiplier, two divisions and control states; parallel segments
// skip 4 products and a division with a zero or clamped operand skips its bit loop
// the last candidate adds a square root (skipped if empty) before its result item
// asynchronous active-low reset clears the query registers and the run state
`timescale 1ns / 1ps
module nearest_segment_search import nss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  nss_cand_if.sink             cand_i,
  nss_res_if.source            res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_GO, S_WAIT, S_PAR, S_CL1, S_CL2, S_DS, S_DSW, S_DT, S_DTW,
    S_UPD, S_FIN, S_SQRT, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    PH_A, PH_B, PH_C, PH_D, PH_E, PH_AC, PH_BB, PH_BE, PH_CD, PH_AE, PH_BD,
    PH_SU, PH_TV, PH_SQ
  } phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [1:0] k_q;

  logic signed [COORD_W-1:0] qs_q [3];
  logic signed [COORD_W-1:0] qe_q [3];
  diff_t u_q [3];
  diff_t v_q [3];
  diff_t w_q [3];
  logic last_q;

  op_t a_q, b_q, c_q, d_q, e_q, dp_q;
  wide_t dv_q, sn_q, sd_q, tn_q, td_q, sum_q;
  logic [Q_W-1:0] sc_q, tc_q;

  logic [DSQ_W-1:0] best_q;
  logic [IDX_W-1:0] best_pos_q;
  logic [CNT_W-1:0] cnt_q;
  logic any_q;

  logic [DSQ_W-1:0] sq_rem_q, sq_res_q, sq_bit_q;
  logic [$clog2(DIST_W)-1:0] sq_cnt_q;
  logic [IDX_W-1:0] st_idx_q;
  logic st_found_q;

  logic ov_q;
  logic [DIST_W-1:0] od_q;
  logic [IDX_W-1:0] oi_q;
  logic of_q;

  op_t mul_a, mul_b, p68;
  wide_t mul_p;
  logic mul_done, div_done, div_start;
  wide_t div_n, div_d;
  logic [Q_W-1:0] div_q;
  logic [DSQ_W-1:0] dsq, sq_try;
  op_t md, mdb;
  logic signed [COORD_W-1:0] cs [3];
  logic signed [COORD_W-1:0] ce [3];
  logic accept, k_end;

  assign cs[0] = cand_i.cand_start_x;
  assign cs[1] = cand_i.cand_start_y;
  assign cs[2] = cand_i.cand_start_z;
  assign ce[0] = cand_i.cand_end_x;
  assign ce[1] = cand_i.cand_end_y;
  assign ce[2] = cand_i.cand_end_z;

  assign cand_i.ready = (state_q == S_IDLE);
  assign accept = cand_i.valid && cand_i.ready;
  assign k_end = (k_q == 2'd2);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (phase_q)
      PH_A: begin mul_a = OP_W'(u_q[k_q]); mul_b = OP_W'(u_q[k_q]); end
      PH_B: begin mul_a = OP_W'(u_q[k_q]); mul_b = OP_W'(v_q[k_q]); end
      PH_C: begin mul_a = OP_W'(v_q[k_q]); mul_b = OP_W'(v_q[k_q]); end
      PH_D: begin mul_a = OP_W'(u_q[k_q]); mul_b = OP_W'(w_q[k_q]); end
      PH_E: begin mul_a = OP_W'(v_q[k_q]); mul_b = OP_W'(w_q[k_q]); end
      PH_AC: begin mul_a = a_q; mul_b = c_q; end
      PH_BB: begin mul_a = b_q; mul_b = b_q; end
      PH_BE: begin mul_a = b_q; mul_b = e_q; end
      PH_CD: begin mul_a = c_q; mul_b = d_q; end
      PH_AE: begin mul_a = a_q; mul_b = e_q; end
      PH_BD: begin mul_a = b_q; mul_b = d_q; end
      PH_SU: begin mul_a = OP_W'(sc_q); mul_b = OP_W'(u_q[k_q]); end
      PH_TV: begin mul_a = OP_W'(tc_q); mul_b = OP_W'(v_q[k_q]); end
      PH_SQ: begin mul_a = dp_q; mul_b = dp_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  nss_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_GO),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign div_start = (state_q == S_DS) || (state_q == S_DT);
  assign div_n = (state_q == S_DT) ? tn_q : sn_q;
  assign div_d = (state_q == S_DT) ? td_q : sd_q;

  nss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign p68 = OP_W'(mul_p);
  assign md = -d_q;
  assign mdb = b_q - d_q;
  assign dsq = (|sum_q[WIDE_W-1:2*DSQ_W]) ? '1 : sum_q[2*DSQ_W-1:DSQ_W];
  assign sq_try = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_A;
      k_q <= '0;
      for (int i = 0; i < 3; i++) begin
        qs_q[i] <= '0;
        qe_q[i] <= '0;
        u_q[i] <= '0;
        v_q[i] <= '0;
        w_q[i] <= '0;
      end
      last_q <= 1'b0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; dp_q <= '0;
      dv_q <= '0; sn_q <= '0; sd_q <= '0; tn_q <= '0; td_q <= '0; sum_q <= '0;
      sc_q <= '0;
      tc_q <= '0;
      best_q <= '1;
      best_pos_q <= '0;
      cnt_q <= '0;
      any_q <= 1'b0;
      sq_rem_q <= '0;
      sq_res_q <= '0;
      sq_bit_q <= '0;
      sq_cnt_q <= '0;
      st_idx_q <= '0;
      st_found_q <= 1'b0;
      ov_q <= 1'b0;
      od_q <= '0;
      oi_q <= '0;
      of_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QSX: qs_q[0] <= cfg_data_i;
          CFG_QSY: qs_q[1] <= cfg_data_i;
          CFG_QSZ: qs_q[2] <= cfg_data_i;
          CFG_QEX: qe_q[0] <= cfg_data_i;
          CFG_QEY: qe_q[1] <= cfg_data_i;
          CFG_QEZ: qe_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == S_OUT && (!ov_q || res_o.ready)) begin
        ov_q <= 1'b1;
      end else if (ov_q && res_o.ready) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 3; i++) begin
              u_q[i] <= DIFF_W'(ce[i]) - DIFF_W'(cs[i]);
              v_q[i] <= DIFF_W'(qe_q[i]) - DIFF_W'(qs_q[i]);
              w_q[i] <= DIFF_W'(cs[i]) - DIFF_W'(qs_q[i]);
            end
            last_q <= cand_i.last_candidate;
            phase_q <= PH_A;
            k_q <= '0;
            state_q <= cand_i.is_connected ? S_FIN : S_GO;
          end
        end
        S_GO: state_q <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            case (phase_q)
              PH_A, PH_B, PH_C, PH_D, PH_E: begin
                case (phase_q)
                  PH_A: a_q <= (k_q == '0) ? p68 : a_q + p68;
                  PH_B: b_q <= (k_q == '0) ? p68 : b_q + p68;
                  PH_C: c_q <= (k_q == '0) ? p68 : c_q + p68;
                  PH_D: d_q <= (k_q == '0) ? p68 : d_q + p68;
                  default: e_q <= (k_q == '0) ? p68 : e_q + p68;
                endcase
                if (k_end) begin
                  k_q <= '0;
                  case (phase_q)
                    PH_A: phase_q <= PH_B;
                    PH_B: phase_q <= PH_C;
                    PH_C: phase_q <= PH_D;
                    PH_D: phase_q <= PH_E;
                    default: phase_q <= PH_AC;
                  endcase
                end else begin
                  k_q <= k_q + 1'b1;
                end
                state_q <= S_GO;
              end
              PH_AC: begin dv_q <= mul_p; phase_q <= PH_BB; state_q <= S_GO; end
              PH_BB: begin dv_q <= dv_q - mul_p; state_q <= S_PAR; end
              PH_BE: begin sn_q <= mul_p; phase_q <= PH_CD; state_q <= S_GO; end
              PH_CD: begin sn_q <= sn_q - mul_p; phase_q <= PH_AE; state_q <= S_GO; end
              PH_AE: begin tn_q <= mul_p; phase_q <= PH_BD; state_q <= S_GO; end
              PH_BD: begin tn_q <= tn_q - mul_p; state_q <= S_CL1; end
              PH_SU: begin
                dp_q <= (OP_W'(w_q[k_q]) <<< FRAC_W) + p68;
                phase_q <= PH_TV;
                state_q <= S_GO;
              end
              PH_TV: begin dp_q <= dp_q - p68; phase_q <= PH_SQ; state_q <= S_GO; end
              PH_SQ: begin
                sum_q <= (k_q == '0) ? mul_p : sum_q + mul_p;
                phase_q <= PH_SU;
                if (k_end) begin
                  k_q <= '0;
                  state_q <= S_UPD;
                end else begin
                  k_q <= k_q + 1'b1;
                  state_q <= S_GO;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_PAR: begin
          if (dv_q[WIDE_W-1] || dv_q == '0) begin
            sn_q <= '0;
            sd_q <= WIDE_W'(1);
            tn_q <= WIDE_W'(e_q);
            td_q <= WIDE_W'(c_q);
            state_q <= S_CL2;
          end else begin
            phase_q <= PH_BE;
            state_q <= S_GO;
          end
        end
        S_CL1: begin
          sd_q <= dv_q;
          if (sn_q[WIDE_W-1]) begin
            sn_q <= '0;
            tn_q <= WIDE_W'(e_q);
            td_q <= WIDE_W'(c_q);
          end else if (sn_q > dv_q) begin
            sn_q <= dv_q;
            tn_q <= WIDE_W'(e_q) + WIDE_W'(b_q);
            td_q <= WIDE_W'(c_q);
          end else begin
            td_q <= dv_q;
          end
          state_q <= S_CL2;
        end
        S_CL2: begin
          if (tn_q[WIDE_W-1]) begin
            tn_q <= '0;
            if (md[OP_W-1]) begin
              sn_q <= '0;
            end else if (md > a_q) begin
              sn_q <= sd_q;
            end else begin
              sn_q <= WIDE_W'(md);
              sd_q <= WIDE_W'(a_q);
            end
          end else if (tn_q > td_q) begin
            tn_q <= td_q;
            if (mdb[OP_W-1]) begin
              sn_q <= '0;
            end else if (mdb > a_q) begin
              sn_q <= sd_q;
            end else begin
              sn_q <= WIDE_W'(mdb);
              sd_q <= WIDE_W'(a_q);
            end
          end
          state_q <= S_DS;
        end
        S_DS: state_q <= S_DSW;
        S_DSW: begin
          if (div_done) begin
            sc_q <= div_q;
            state_q <= S_DT;
          end
        end
        S_DT: state_q <= S_DTW;
        S_DTW: begin
          if (div_done) begin
            tc_q <= div_q;
            phase_q <= PH_SU;
            k_q <= '0;
            state_q <= S_GO;
          end
        end
        S_UPD: begin
          if (!any_q || dsq < best_q) begin
            best_q <= dsq;
            best_pos_q <= IDX_W'(cnt_q);
            any_q <= 1'b1;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (last_q) begin
            st_idx_q <= any_q ? best_pos_q : '0;
            st_found_q <= any_q;
            sq_rem_q <= best_q;
            sq_res_q <= any_q ? '0 : DSQ_W'({DIST_W{1'b1}});
            sq_bit_q <= DSQ_W'(1) << (DSQ_W - 2);
            sq_cnt_q <= '0;
            best_q <= '1;
            best_pos_q <= '0;
            cnt_q <= '0;
            any_q <= 1'b0;
            state_q <= any_q ? S_SQRT : S_OUT;
          end else begin
            cnt_q <= (cnt_q == CNT_W'(MAX_SEGMENTS - 1)) ? '0 : cnt_q + 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_SQRT: begin
          if (sq_rem_q >= sq_try) begin
            sq_rem_q <= sq_rem_q - sq_try;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          sq_cnt_q <= sq_cnt_q + 1'b1;
          if (sq_cnt_q == ($clog2(DIST_W))'(DIST_W - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_q || res_o.ready) begin
            od_q <= sq_res_q[DIST_W-1:0];
            oi_q <= st_idx_q;
            of_q <= st_found_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid = ov_q;
  assign res_o.nearest_dist = od_q;
  assign res_o.best_index = oi_q;
  assign res_o.found = of_q;

endmodule

// ===== rtl/nss_mul.sv =====
// digit-serial signed multiplier, 17 bits of one operand per cycle
`timescale 1ns / 1ps
module nss_mul import nss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  op_t   a_i,
  input  op_t   b_i,
  output logic  done_o,
  output wide_t p_o
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_NEG} mstate_e;

  mstate_e state_q;
  logic [OP_W-1:0] mag_a_q, mag_b_q;
  logic neg_q;
  logic [WIDE_W-1:0] acc_q;
  logic [$clog2(NDIG)-1:0] cnt_q;
  wide_t p_q;
  logic done_q;

  logic [OP_W-1:0] abs_a, abs_b;
  logic [OP_W+DIG_W:0] hi_sum;
  logic [WIDE_W+DIG_W:0] joined;

  assign abs_a = a_i[OP_W-1] ? OP_W'(-a_i) : OP_W'(a_i);
  assign abs_b = b_i[OP_W-1] ? OP_W'(-b_i) : OP_W'(b_i);
  assign hi_sum = (OP_W+DIG_W+1)'(acc_q[WIDE_W-1:OP_W])
                + (OP_W+DIG_W+1)'(mag_a_q * mag_b_q[DIG_W-1:0]);
  assign joined = {hi_sum, acc_q[OP_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      mag_a_q <= '0;
      mag_b_q <= '0;
      neg_q <= 1'b0;
      acc_q <= '0;
      cnt_q <= '0;
      p_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            mag_a_q <= abs_a;
            mag_b_q <= abs_b;
            neg_q <= a_i[OP_W-1] ^ b_i[OP_W-1];
            acc_q <= '0;
            cnt_q <= '0;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          acc_q <= joined[WIDE_W+DIG_W-1:DIG_W];
          mag_b_q <= mag_b_q >> DIG_W;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ($clog2(NDIG))'(NDIG - 1)) begin
            state_q <= M_NEG;
          end
        end
        M_NEG: begin
          p_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
          done_q <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o = p_q;

endmodule

// ===== rtl/nss_div.sv =====
// restoring divider giving a clamped q1.32 fraction, one bit per cycle
`timescale 1ns / 1ps
module nss_div import nss_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wide_t          n_i,
  input  wide_t          d_i,
  output logic           done_o,
  output logic [Q_W-1:0] q_o
);

  typedef enum logic {D_IDLE, D_RUN} dstate_e;

  dstate_e state_q;
  logic [WIDE_W-1:0] r_q, d_q;
  logic [Q_W-1:0] q_q;
  logic [$clog2(FRAC_W)-1:0] cnt_q;
  logic done_q;

  logic [WIDE_W:0] r2, diff;
  logic ge;

  assign r2 = {r_q, 1'b0};
  assign diff = r2 - {1'b0, d_q};
  assign ge = !diff[WIDE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      r_q <= '0;
      d_q <= '0;
      q_q <= '0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            if (n_i[WIDE_W-1] || n_i == '0 || d_i[WIDE_W-1] || d_i == '0) begin
              q_q <= '0;
              done_q <= 1'b1;
            end else if (n_i >= d_i) begin
              q_q <= Q_W'(1) << FRAC_W;
              done_q <= 1'b1;
            end else begin
              r_q <= WIDE_W'(n_i);
              d_q <= WIDE_W'(d_i);
              q_q <= '0;
              cnt_q <= '0;
              state_q <= D_RUN;
            end
          end
        end
        D_RUN: begin
          r_q <= ge ? diff[WIDE_W-1:0] : r2[WIDE_W-1:0];
          q_q <= {q_q[Q_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ($clog2(FRAC_W))'(FRAC_W - 1)) begin
            done_q <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign q_o = q_q;

endmodule

// ===== rtl/nss_checker.sv =====
// port-level checks for the nearest segment search block
`timescale 1ns / 1ps
module nss_checker import nss_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DIST_W-1:0] out_dist_i,
  input logic [IDX_W-1:0]  out_idx_i,
  input logic              out_found_i
);

  // stalled result item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_dist_i)
      && $stable(out_idx_i) && $stable(out_found_i))
    else $error("stalled result changed");

  // empty run reports saturated distance and index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_dist_i == '1 && out_idx_i == '0)
    else $error("empty run result malformed");

  // busy right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after accept");

  // a new result only comes out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result without work");

endmodule

bind nearest_segment_search nss_checker u_nss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cand_i.valid),
  .in_ready_i  (cand_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_dist_i  (res_o.nearest_dist),
  .out_idx_i   (res_o.best_index),
  .out_found_i (res_o.found)
);
